/* hdl/m3inv_pkg.sv */
// Shared types and index tables for the 3x3 matrix inverse block.
package m3inv_pkg;

  localparam int unsigned N_ELEM     = 9;
  localparam int unsigned ENTRY_BITS = 48;

  // Element indices for each cofactor k = r*3+c: cof = a*b - c*d, odd
  // positions already have their operand pairs swapped for the sign.
  localparam logic [3:0] CF_A [N_ELEM] = '{4'd4, 4'd5, 4'd3, 4'd2, 4'd0, 4'd1, 4'd1, 4'd2, 4'd0};
  localparam logic [3:0] CF_B [N_ELEM] = '{4'd8, 4'd6, 4'd7, 4'd7, 4'd8, 4'd6, 4'd5, 4'd3, 4'd4};
  localparam logic [3:0] CF_C [N_ELEM] = '{4'd5, 4'd3, 4'd4, 4'd1, 4'd2, 4'd0, 4'd2, 4'd0, 4'd1};
  localparam logic [3:0] CF_D [N_ELEM] = '{4'd7, 4'd8, 4'd6, 4'd8, 4'd6, 4'd7, 4'd4, 4'd5, 4'd3};

  // Transpose: output entry (i,j) uses cofactor (j,i).
  localparam logic [3:0] TR [N_ELEM] = '{4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8};

  typedef struct packed {
    logic       load;
    logic [3:0] load_idx;
    logic       minor_en;
    logic [3:0] minor_idx;
    logic       det_clr;
    logic       det_en;
    logic [3:0] det_idx;
    logic       det_fin;
    logic       div_init;
    logic [3:0] ent_idx;
    logic       div_step;
    logic       emit;
    logic       emit_last;
  } dp_cmd_t;

endpackage

/* hdl/m3inv_dp.sv */
// Datapath: element store, cofactor and determinant MACs, serial divider, output register.
module m3inv_dp #(
  parameter int unsigned E = 16,
  parameter int unsigned F = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  m3inv_pkg::dp_cmd_t                cmd,
  input  logic [E-1:0]                      in_element,
  output logic                              out_valid,
  output logic [m3inv_pkg::ENTRY_BITS-1:0]  out_inverse_entry,
  output logic                              out_singular,
  output logic                              out_last
);

  localparam int unsigned CW = 2*E + 1;
  localparam int unsigned PW = E + CW;
  localparam int unsigned AW = PW + 2;
  localparam int unsigned NW = CW + F;
  localparam int unsigned OW = m3inv_pkg::ENTRY_BITS;
  localparam int unsigned XW = NW + OW;

  logic signed [E-1:0]    elem_r [m3inv_pkg::N_ELEM];
  logic signed [CW-1:0]   cof_r  [m3inv_pkg::N_ELEM];
  logic signed [2*E-1:0]  pa_r, pc_r;
  logic                   mv_r;
  logic [3:0]             midx_r;
  logic signed [PW-1:0]   dprod_r;
  logic                   dv_r;
  logic signed [AW-1:0]   acc_r;
  logic [AW-1:0]          det_r;
  logic                   dneg_r, sing_r, neg_r;
  logic [AW-1:0]          rem_r;
  logic [NW-1:0]          qn_r;
  logic                   out_valid_r, out_singular_r, out_last_r;
  logic [OW-1:0]          out_entry_r;

  logic signed [CW-1:0]   cof_sel;
  logic [CW-1:0]          cof_mag;
  logic [AW:0]            rem_sh, den_x;
  logic                   ge;
  logic [XW-1:0]          q_x, lim_x;
  logic [OW-1:0]          lim, sat, entry;

  assign cof_sel = cof_r[m3inv_pkg::TR[cmd.ent_idx]];
  assign cof_mag = cof_sel[CW-1] ? CW'(-cof_sel) : CW'(cof_sel);

  assign rem_sh = {rem_r, qn_r[NW-1]};
  assign den_x  = {1'b0, det_r};
  assign ge     = rem_sh >= den_x;

  // saturate the quotient magnitude; negative side reaches one further
  assign lim   = neg_r ? {1'b1, {(OW-1){1'b0}}} : {1'b0, {(OW-1){1'b1}}};
  assign q_x   = XW'(qn_r);
  assign lim_x = XW'(lim);
  assign sat   = (q_x > lim_x) ? lim : q_x[OW-1:0];
  assign entry = sing_r ? '0 : (neg_r ? OW'(-sat) : sat);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      elem_r[cmd.load_idx] <= in_element;
    end
    if (cmd.minor_en) begin
      pa_r <= elem_r[m3inv_pkg::CF_A[cmd.minor_idx]] * elem_r[m3inv_pkg::CF_B[cmd.minor_idx]];
      pc_r <= elem_r[m3inv_pkg::CF_C[cmd.minor_idx]] * elem_r[m3inv_pkg::CF_D[cmd.minor_idx]];
      midx_r <= cmd.minor_idx;
    end
    if (mv_r) begin
      cof_r[midx_r] <= CW'(pa_r) - CW'(pc_r);
    end
    if (cmd.det_en) begin
      dprod_r <= PW'(elem_r[cmd.det_idx]) * PW'(cof_r[cmd.det_idx]);
    end
    if (cmd.det_clr) begin
      acc_r <= '0;
    end else if (dv_r) begin
      acc_r <= acc_r + AW'(dprod_r);
    end
    if (cmd.det_fin) begin
      det_r  <= acc_r[AW-1] ? AW'(-acc_r) : AW'(acc_r);
      dneg_r <= acc_r[AW-1];
      sing_r <= (acc_r == '0);
    end
    if (cmd.div_init) begin
      neg_r <= cof_sel[CW-1] ^ dneg_r;
      qn_r  <= {cof_mag, {F{1'b0}}};
      rem_r <= '0;
    end else if (cmd.div_step) begin
      rem_r <= ge ? AW'(rem_sh - den_x) : rem_sh[AW-1:0];
      qn_r  <= {qn_r[NW-2:0], ge};
    end
    if (cmd.emit) begin
      out_entry_r    <= entry;
      out_singular_r <= sing_r;
      out_last_r     <= cmd.emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r        <= 1'b0;
      dv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mv_r        <= cmd.minor_en;
      dv_r        <= cmd.det_en;
      out_valid_r <= cmd.emit;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_inverse_entry = out_entry_r;
  assign out_singular      = out_singular_r;
  assign out_last          = out_last_r;

endmodule

/* hdl/m3inv_ctrl.sv */
// Controller: load, cofactor, determinant and per-entry divide sequencing.
module m3inv_ctrl #(
  parameter int unsigned NW = 49
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output m3inv_pkg::dp_cmd_t cmd
);

  localparam int unsigned DCW = $clog2(NW + 1);

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_MINOR = 3'd1;
  localparam logic [2:0] S_DET   = 3'd2;
  localparam logic [2:0] S_DETF  = 3'd3;
  localparam logic [2:0] S_INIT  = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]     state_r, state_nxt;
  logic [3:0]     cnt_r, cnt_nxt;
  logic [3:0]     ent_r, ent_nxt;
  logic [DCW-1:0] dcnt_r, dcnt_nxt;
  logic           accept;

  assign busy   = (state_r != S_LOAD);
  assign accept = start && !busy;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ent_nxt   = ent_r;
    dcnt_nxt  = dcnt_r;
    cmd       = '0;
    cmd.load_idx  = cnt_r;
    cmd.minor_idx = cnt_r;
    cmd.det_idx   = cnt_r;
    cmd.ent_idx   = ent_r;
    cmd.emit_last = (ent_r == 4'd8);
    unique case (state_r)
      S_LOAD: begin
        if (accept) begin
          cmd.load = 1'b1;
          if (cnt_r == 4'd8) begin
            cnt_nxt   = '0;
            state_nxt = S_MINOR;
          end else begin
            cnt_nxt = cnt_r + 4'd1;
          end
        end
      end
      S_MINOR: begin
        // products issued for k = 0..8, last cofactor written in the following cycle
        cmd.minor_en = (cnt_r != 4'd9);
        if (cnt_r == 4'd9) begin
          cnt_nxt   = '0;
          state_nxt = S_DET;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      S_DET: begin
        cmd.det_clr = (cnt_r == 4'd0);
        cmd.det_en  = (cnt_r != 4'd3);
        if (cnt_r == 4'd3) begin
          cnt_nxt   = '0;
          state_nxt = S_DETF;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      S_DETF: begin
        cmd.det_fin = 1'b1;
        ent_nxt     = '0;
        state_nxt   = S_INIT;
      end
      S_INIT: begin
        cmd.div_init = 1'b1;
        dcnt_nxt     = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_nxt     = dcnt_r + DCW'(1);
        if (dcnt_r == DCW'(NW - 1)) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (ent_r == 4'd8) begin
          state_nxt = S_LOAD;
        end else begin
          ent_nxt   = ent_r + 4'd1;
          state_nxt = S_INIT;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      ent_r   <= '0;
      dcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ent_r   <= ent_nxt;
      dcnt_r  <= dcnt_nxt;
    end
  end

endmodule

/* hdl/matrix3x3_inverse.sv */
// 3x3 matrix inverse by adjugate: top level joining controller and datapath.
//
// Load nine signed elements in row-major order, one word per cycle while busy
// is low (start high). The ninth word raises busy; the block then forms the nine
// cofactors on one shared pair of multipliers, the determinant on one multiplier,
// and divides each transposed cofactor, shifted left by FRAC_BITS, by the
// determinant in a restoring divider that retires one quotient bit a cycle, for
// NW = 2*ELEMENT_BITS + 1 + FRAC_BITS quotient bits per entry. A new matrix is
// taken only once busy falls after the ninth entry. Results come one at a time
// on out_valid, each for a single cycle; the receiver cannot stall them. A zero
// determinant gives zero entries with out_singular set; out_last marks the ninth
// entry.
module matrix3x3_inverse #(
  parameter int unsigned ELEMENT_BITS = 16,
  parameter int unsigned FRAC_BITS    = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [ELEMENT_BITS-1:0]           in_element,
  output logic                              out_valid,
  output logic [m3inv_pkg::ENTRY_BITS-1:0]  out_inverse_entry,
  output logic                              out_singular,
  output logic                              out_last
);

  localparam int unsigned NW = 2*ELEMENT_BITS + 1 + FRAC_BITS;

  m3inv_pkg::dp_cmd_t cmd;

  m3inv_ctrl #(
    .NW (NW)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  m3inv_dp #(
    .E (ELEMENT_BITS),
    .F (FRAC_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_element        (in_element),
    .out_valid         (out_valid),
    .out_inverse_entry (out_inverse_entry),
    .out_singular      (out_singular),
    .out_last          (out_last)
  );

`ifndef SYNTHESIS
  a_valid_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result word without a busy cycle before it");

  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> !busy)
    else $error("still busy when last word is shown");

  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_singular) |-> (out_inverse_entry == '0))
    else $error("singular matrix gave nonzero entry");

  a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted word");
`endif

endmodule
